// ===== hw/rtl/u8sfi_pkg.sv =====
// u8sfi_pkg: types, constants and the lead-byte decode for the utf-8 first-index search
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package u8sfi_pkg;

    // field and register widths
    localparam int BYTE_W       = 8;
    localparam int NEEDLE_W     = 64;
    localparam int NEEDLE_LEN_W = 4;
    localparam int CHAR_IDX_W   = 31;
    localparam int RESULT_W     = 32;
    localparam int SEG_W        = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int NEEDLE_SLOTS = NEEDLE_W / BYTE_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 1'd1;

    // character counter saturation point
    localparam logic [CHAR_IDX_W-1:0] CHAR_IDX_MAX = {CHAR_IDX_W{1'b1}};

    // lead-byte masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2B     = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_2B     = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_3B     = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_3B     = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_4B     = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_4B     = 8'hF0;

    // one window position: byte, start-of-character flag and its character index
    typedef struct packed {
        logic [BYTE_W-1:0]     data;
        logic                  start;
        logic [CHAR_IDX_W-1:0] idx;
    } t_cell;

    // character position of the byte being taken
    typedef struct packed {
        logic                  is_start;
        logic [CHAR_IDX_W-1:0] idx;
    } t_char_pos;

    // number of continuation bytes that follow a lead byte
    function automatic logic [SEG_W-1:0] cont_bytes(input logic [BYTE_W-1:0] c);
        logic [SEG_W-1:0] n;
        if (c < ASCII_LIMIT)                n = 2'd0;
        else if ((c & MASK_2B) == LEAD_2B)  n = 2'd1;
        else if ((c & MASK_3B) == LEAD_3B)  n = 2'd2;
        else if ((c & MASK_4B) == LEAD_4B)  n = 2'd3;
        else                                n = 2'd0;
        return n;
    endfunction

endpackage

// ===== hw/rtl/u8sfi_front.sv =====
// u8sfi_front: splits the byte stream into characters and counts them
// depends on u8sfi_pkg
`timescale 1ns / 1ps

module u8sfi_front
    import u8sfi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_clear,
    input  logic [BYTE_W-1:0] i_byte,
    output t_char_pos         o_pos
);

    logic [SEG_W-1:0]      r_seg;
    logic [SEG_W-1:0]      n_seg;
    logic [CHAR_IDX_W-1:0] r_cnt;
    logic [CHAR_IDX_W-1:0] n_cnt;
    logic                  is_start;

    // position of the current byte
    assign is_start     = (r_seg == '0);
    assign o_pos.is_start = is_start;
    assign o_pos.idx    = is_start ? r_cnt :
                          ((r_cnt == '0) ? '0 : r_cnt - CHAR_IDX_W'(1));

    // segment and counter update
    always_comb begin
        n_seg = r_seg;
        n_cnt = r_cnt;
        if (i_take) begin
            if (is_start) begin
                n_seg = cont_bytes(i_byte);
                if (r_cnt != CHAR_IDX_MAX) n_cnt = r_cnt + CHAR_IDX_W'(1);
            end else begin
                n_seg = r_seg - SEG_W'(1);
            end
        end
        if (i_clear) begin
            n_seg = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= '0;
            r_cnt <= '0;
        end else begin
            r_seg <= n_seg;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/u8sfi_cell.sv =====
// u8sfi_cell: one position of the byte window; shifts on each byte and compares its incoming byte
// depends on u8sfi_pkg
`timescale 1ns / 1ps

module u8sfi_cell
    import u8sfi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_clear,
    input  t_cell                 i_prev,
    input  logic                  i_in_use,
    input  logic                  i_is_last,
    input  logic [BYTE_W-1:0]     i_needle_byte,
    output t_cell                 o_cell,
    output logic                  o_hit,
    output logic                  o_tail_start,
    output logic [CHAR_IDX_W-1:0] o_tail_idx
);

    t_cell r_cell;

    // compare on the value this cell takes at the shift
    assign o_hit        = !i_in_use || (i_prev.data == i_needle_byte);
    assign o_tail_start = i_is_last && i_prev.start;
    assign o_tail_idx   = i_is_last ? i_prev.idx : '0;
    assign o_cell       = r_cell;

    // window storage; only the start flag needs clearing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cell.start <= 1'b0;
        end else if (i_shift) begin
            r_cell.start <= i_prev.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_cell.data <= i_prev.data;
            r_cell.idx  <= i_prev.idx;
        end
    end

endmodule

// ===== hw/rtl/utf8_substring_first_index.sv =====
// utf8_substring_first_index: first character index of a needle in a streamed utf-8 string
// result: registered; shows in the cycle after the end-of-string request is accepted
// throughput: one request per cycle while the input is not stalled, set by the shift and compare of the window
// the input stalls only while a result is held and the output side stalls
// reset: synchronous, active low; clears control and configuration registers, window flags and all string state
// depends on u8sfi_pkg, u8sfi_front and u8sfi_cell
`timescale 1ns / 1ps

module utf8_substring_first_index
    import u8sfi_pkg::*;
#(
    parameter int NEEDLE_MAX_BYTES = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [NEEDLE_W-1:0]        i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [BYTE_W-1:0]          i_hay_byte,
    input  logic                       i_has_byte,
    input  logic                       i_end_of_string,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [RESULT_W-1:0] o_char_index
);

    localparam int N     = NEEDLE_MAX_BYTES;
    localparam int LEN_W = $clog2(N + 1);

    // configuration registers
    logic [NEEDLE_W-1:0]     r_needle;
    logic [NEEDLE_LEN_W-1:0] r_len_cfg;
    logic [BYTE_W-1:0]       needle_arr [NEEDLE_SLOTS];
    logic [LEN_W-1:0]        len_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle  <= '0;
            r_len_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEEDLE_BYTES:  r_needle  <= i_cfg_data;
                CFG_NEEDLE_LENGTH: r_len_cfg <= i_cfg_data[NEEDLE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < NEEDLE_SLOTS; j++) begin
            needle_arr[j] = r_needle[j*BYTE_W +: BYTE_W];
        end
    end

    assign len_eff = (r_len_cfg > NEEDLE_LEN_W'(N)) ? LEN_W'(N)
                                                    : r_len_cfg[LEN_W-1:0];

    // handshake
    logic in_acc;
    logic out_acc;
    logic take;
    logic finish;
    logic r_out_valid;

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign take    = in_acc && i_has_byte;
    assign finish  = in_acc && i_end_of_string;

    // character split
    t_char_pos pos;

    u8sfi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_clear (finish),
        .i_byte  (i_hay_byte),
        .o_pos   (pos)
    );

    // window chain of cells
    t_cell                 cell_in    [N];
    t_cell                 cell_q     [N];
    logic [N-1:0]          hit;
    logic [N-1:0]          tail_start;
    logic [CHAR_IDX_W-1:0] tail_idx   [N];

    assign cell_in[0] = '{data: i_hay_byte, start: pos.is_start, idx: pos.idx};

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic                    in_use;
        logic                    is_last;
        logic [NEEDLE_LEN_W-1:0] slot;

        if (k > 0) begin : g_link
            assign cell_in[k] = cell_q[k-1];
        end

        assign in_use  = (LEN_W'(k) < len_eff);
        assign is_last = (LEN_W'(k + 1) == len_eff);
        assign slot    = NEEDLE_LEN_W'(len_eff) - NEEDLE_LEN_W'(k + 1);

        u8sfi_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (take),
            .i_clear       (finish),
            .i_prev        (cell_in[k]),
            .i_in_use      (in_use),
            .i_is_last     (is_last),
            .i_needle_byte (needle_arr[slot[2:0]]),
            .o_cell        (cell_q[k]),
            .o_hit         (hit[k]),
            .o_tail_start  (tail_start[k]),
            .o_tail_idx    (tail_idx[k])
        );
    end

    // oldest needle position of the new window
    logic [CHAR_IDX_W-1:0] tail_idx_or;

    always_comb begin
        tail_idx_or = '0;
        for (int k = 0; k < N; k++) begin
            tail_idx_or = tail_idx_or | tail_idx[k];
        end
    end

    // match tracking
    logic [LEN_W-1:0]      r_seen;
    logic [LEN_W-1:0]      seen_new;
    logic                  r_pending;
    logic [CHAR_IDX_W-1:0] r_pending_idx;
    logic                  r_found;
    logic [CHAR_IDX_W-1:0] r_first_idx;
    logic                  found_a;
    logic [CHAR_IDX_W-1:0] first_a;
    logic                  pend_b;
    logic [CHAR_IDX_W-1:0] pidx_b;
    logic                  cand;
    logic                  found_c;
    logic [CHAR_IDX_W-1:0] first_c;
    logic [RESULT_W-1:0]   result;

    assign seen_new = (r_seen == LEN_W'(N)) ? r_seen : r_seen + LEN_W'(1);

    always_comb begin
        // a waiting candidate is confirmed by a character start
        found_a = r_found;
        first_a = r_first_idx;
        if (take && r_pending && pos.is_start && !r_found) begin
            found_a = 1'b1;
            first_a = r_pending_idx;
        end

        // new candidate on the shifted window
        cand = take && !found_a && (len_eff != '0) && (seen_new >= len_eff)
               && (|tail_start) && (&hit);
        pend_b = take ? 1'b0 : r_pending;
        pidx_b = r_pending_idx;
        if (cand) begin
            pend_b = 1'b1;
            pidx_b = tail_idx_or;
        end

        // end of string also closes a waiting candidate
        found_c = found_a || pend_b;
        first_c = (pend_b && !found_a) ? pidx_b : first_a;

        if (len_eff == '0)  result = '0;
        else if (found_c)   result = {1'b0, first_c};
        else                result = '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_seen        <= '0;
            r_pending     <= 1'b0;
            r_pending_idx <= '0;
            r_found       <= 1'b0;
            r_first_idx   <= '0;
        end else begin
            if (take) r_seen <= seen_new;
            r_pending     <= pend_b;
            r_pending_idx <= pidx_b;
            r_found       <= found_a;
            r_first_idx   <= first_a;
        end
    end

    // output register
    logic [RESULT_W-1:0] r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) r_out_idx <= result;
    end

    assign o_valid      = r_out_valid;
    assign o_char_index = signed'(r_out_idx);

endmodule
